/* hdl/ctru_pkg.sv */
package ctru_pkg;

  localparam int LEN_BITS_DEF   = 16;
  localparam int MAX_FIELDS_DEF = 1024;

  localparam int KIND_W  = 2;
  localparam int ERR_W   = 2;
  localparam int LEN_W   = 16;
  localparam int INDEX_W = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_EOR_BACKSLASH  = 2'd0,
    ERR_NULL_NONEMPTY  = 2'd1,
    ERR_DATA_AFTER_NULL = 2'd2
  } err_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOR  = 1'b1;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NULL_MARK = 8'h4E;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_V         = 8'h76;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         out_byte;
    logic               is_null;
    logic [LEN_W-1:0]   field_len;
    logic [INDEX_W-1:0] field_index;
    logic               row_end;
    err_t               err_code;
  } res_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      CH_B:    r = 8'd8;
      CH_F:    r = 8'd12;
      CH_N:    r = 8'd10;
      CH_R:    r = 8'd13;
      CH_T:    r = 8'd9;
      CH_V:    r = 8'd11;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

/* hdl/copy_text_row_unescaper.sv */
// Unescaper for one row of bulk-copy text, one byte per input transaction.
// Input channel: in_valid/in_stall with op, in_byte, in_glyph. op selects a
// row byte or the end-of-row mark. Output channel: out_valid/out_stall with
// kind (data byte, field end, error) and its fields; a transaction produces
// zero or one output transaction.
// Throughput: one input transaction per cycle while in_stall is low, set by
// the single pass of escape decode and counter update between the input
// port and the result register. A result is registered into the output
// register, or into the skid register while the output is stalled.
// The result register is backed by a one-entry skid register; in_stall is
// high only while the skid register is occupied, i.e. after the receiver
// has stalled with a result waiting and another result arrived behind it.
// Reset clears the escape, NULL, drop state and the length and field
// counters and empties both output registers; the block is ready the cycle
// after reset.
// After an error the rest of the row gives no output; the end-of-row
// transaction clears all row state.
module copy_text_row_unescaper
  import ctru_pkg::*;
#(
  parameter int LEN_BITS   = LEN_BITS_DEF,
  parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [7:0]           in_byte,
  input  logic                 in_glyph,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KIND_W-1:0]    kind,
  output logic [7:0]           out_byte,
  output logic                 is_null,
  output logic [LEN_W-1:0]     field_len,
  output logic [INDEX_W-1:0]   field_index,
  output logic                 row_end,
  output logic [ERR_W-1:0]     err_code
);

  localparam int IDX_BITS = (MAX_FIELDS > 2) ? $clog2(MAX_FIELDS) : 1;
  localparam int LEN_XW   = (LEN_BITS > LEN_W) ? LEN_BITS : LEN_W;
  localparam int IDX_XW   = (IDX_BITS > INDEX_W) ? IDX_BITS : INDEX_W;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(MAX_FIELDS - 1);

  logic                escape_pending, escape_pending_next;
  logic                null_field, null_field_next;
  logic [LEN_BITS-1:0] cur_len, cur_len_next;
  logic [IDX_BITS-1:0] cur_index, cur_index_next;
  logic                drop_rest, drop_rest_next;

  res_t res;
  logic res_valid;
  logic accept;

  res_t out_reg, skid_reg;
  logic skid_valid;
  logic out_free;

  logic [LEN_XW-1:0] len_ext;
  logic [IDX_XW-1:0] idx_ext;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign len_ext = LEN_XW'(cur_len);
  assign idx_ext = IDX_XW'(cur_index);

  always_comb begin
    logic do_data, do_end, do_err, last;
    logic [7:0] data_b;
    err_t code;
    do_data = 1'b0;
    do_end  = 1'b0;
    do_err  = 1'b0;
    last    = 1'b0;
    data_b  = in_byte;
    code    = ERR_EOR_BACKSLASH;

    escape_pending_next = escape_pending;
    null_field_next     = null_field;
    cur_len_next        = cur_len;
    cur_index_next      = cur_index;
    drop_rest_next      = drop_rest;

    if (op == OP_EOR) begin
      if (!drop_rest) begin
        if (escape_pending) begin
          do_err = 1'b1;
          code   = ERR_EOR_BACKSLASH;
        end else begin
          do_end = 1'b1;
          last   = 1'b1;
        end
      end
    end else if (!drop_rest) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (in_byte == CH_NULL_MARK) begin
          if (null_field) begin
            do_err = 1'b1;
            code   = ERR_DATA_AFTER_NULL;
          end else if (cur_len != '0) begin
            do_err = 1'b1;
            code   = ERR_NULL_NONEMPTY;
          end else begin
            null_field_next = 1'b1;
          end
        end else begin
          do_data = 1'b1;
          data_b  = unescape(in_byte);
        end
      end else if (in_glyph) begin
        do_data = 1'b1;
      end else if (in_byte == CH_TAB) begin
        do_end = 1'b1;
      end else if (in_byte == CH_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else begin
        do_data = 1'b1;
      end
    end

    if (do_data && null_field) begin
      do_data = 1'b0;
      do_err  = 1'b1;
      code    = ERR_DATA_AFTER_NULL;
    end

    res       = '0;
    res_valid = do_data || do_end || do_err;
    if (do_err) begin
      res.kind            = KIND_ERR;
      res.err_code        = code;
      drop_rest_next      = 1'b1;
      escape_pending_next = 1'b0;
    end else if (do_data) begin
      res.kind     = KIND_DATA;
      res.out_byte = data_b;
      if (cur_len != LEN_MAX) begin
        cur_len_next = cur_len + 1'b1;
      end
    end else if (do_end) begin
      res.kind        = KIND_END;
      res.is_null     = null_field;
      res.field_len   = (len_ext > LEN_XW'(16'hFFFF)) ? 16'hFFFF : len_ext[LEN_W-1:0];
      res.field_index = (idx_ext > IDX_XW'(10'h3FF)) ? 10'h3FF : idx_ext[INDEX_W-1:0];
      res.row_end     = last;
      null_field_next = 1'b0;
      cur_len_next    = '0;
      if (cur_index < IDX_MAX) begin
        cur_index_next = cur_index + 1'b1;
      end
    end

    if (op == OP_EOR) begin
      escape_pending_next = 1'b0;
      null_field_next     = 1'b0;
      cur_len_next        = '0;
      cur_index_next      = '0;
      drop_rest_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      null_field     <= 1'b0;
      cur_len        <= '0;
      cur_index      <= '0;
      drop_rest      <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      null_field     <= null_field_next;
      cur_len        <= cur_len_next;
      cur_index      <= cur_index_next;
      drop_rest      <= drop_rest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg   <= res;
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_reg   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign kind        = out_reg.kind;
  assign out_byte    = out_reg.out_byte;
  assign is_null     = out_reg.is_null;
  assign field_len   = out_reg.field_len;
  assign field_index = out_reg.field_index;
  assign row_end     = out_reg.row_end;
  assign err_code    = out_reg.err_code;

endmodule

/* hdl/ctru_checker.sv */
module ctru_checker
  import ctru_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [KIND_W-1:0]  kind,
  input logic [7:0]         out_byte,
  input logic               is_null,
  input logic [LEN_W-1:0]   field_len,
  input logic [INDEX_W-1:0] field_index,
  input logic               row_end,
  input logic [ERR_W-1:0]   err_code
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(field_len) && $stable(field_index) && $stable(err_code))
    else $error("output changed while stalled");

  // input stall only arises behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> !is_null && field_len == '0
      && field_index == '0 && !row_end && err_code == '0)
    else $error("data transaction carries field-end or error bits");

  a_null_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END && is_null |-> field_len == '0)
    else $error("NULL field with nonzero length");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> out_byte == '0 && !row_end
      && (err_code == ERR_EOR_BACKSLASH || err_code == ERR_NULL_NONEMPTY
          || err_code == ERR_DATA_AFTER_NULL))
    else $error("malformed error transaction");

endmodule

bind copy_text_row_unescaper ctru_checker u_ctru_checker (.*);

/* verif/tb_copy_text_row_unescaper.sv */
`timescale 1ns / 1ps

module tb_copy_text_row_unescaper
  import ctru_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_BYTE;
  logic [7:0] in_byte = 8'h00;
  logic in_glyph = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [7:0] out_byte;
  logic is_null;
  logic [LEN_W-1:0] field_len;
  logic [INDEX_W-1:0] field_index;
  logic row_end;
  logic [ERR_W-1:0] err_code;

  copy_text_row_unescaper u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .in_byte(in_byte), .in_glyph(in_glyph),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .out_byte(out_byte), .is_null(is_null),
    .field_len(field_len), .field_index(field_index),
    .row_end(row_end), .err_code(err_code)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic       op;
    logic [7:0] b;
    logic       g;
    bit         typed;
    bit         any;
    res_t       r;
  } stim_row_t;

  // row state of the unescaper
  bit               esc_seen;
  bit               null_seen;
  logic [LEN_W-1:0] len_cnt;
  logic [INDEX_W-1:0] idx_cnt;
  bit               skip_row;

  res_t      row_out_q[$];
  stim_row_t directed_rows[$];

  // typed expectation riding along with the payload
  bit   row_typed = 1'b0;
  bit   row_any = 1'b0;
  res_t row_exp = '0;

  bit calm = 1'b0;
  int fail_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int n_end = 0;
  int n_err = 0;
  int n_rand = 0;

  logic [7:0] esc_set [8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_V, CH_BACKSLASH, CH_TAB};

  function automatic res_t data_res(logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.out_byte = b;
    return r;
  endfunction

  function automatic res_t end_res(logic nl, logic [LEN_W-1:0] len,
                                   logic [INDEX_W-1:0] idx, logic last);
    res_t r;
    r = '0;
    r.kind = KIND_END;
    r.is_null = nl;
    r.field_len = len;
    r.field_index = idx;
    r.row_end = last;
    return r;
  endfunction

  function automatic res_t err_res(err_t c);
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.err_code = c;
    return r;
  endfunction

  function automatic res_t raise_err(err_t c);
    skip_row = 1'b1;
    esc_seen = 1'b0;
    return err_res(c);
  endfunction

  function automatic res_t put_data(logic [7:0] b);
    if (null_seen) return raise_err(ERR_DATA_AFTER_NULL);
    if (len_cnt != {LEN_W{1'b1}}) len_cnt = len_cnt + 1'b1;
    return data_res(b);
  endfunction

  function automatic res_t close_field(logic last);
    res_t r;
    r = end_res(null_seen, len_cnt, idx_cnt, last);
    null_seen = 1'b0;
    len_cnt = '0;
    if (idx_cnt != INDEX_W'(MAX_FIELDS_DEF - 1)) idx_cnt = idx_cnt + 1'b1;
    return r;
  endfunction

  function automatic bit unescape_step(input logic op_i, input logic [7:0] b, input logic g,
                                       output res_t r);
    bit any;
    logic [7:0] d;
    r = '0;
    any = 1'b0;
    if (op_i == OP_EOR) begin
      if (!skip_row) begin
        any = 1'b1;
        if (esc_seen) r = err_res(ERR_EOR_BACKSLASH);
        else r = close_field(1'b1);
      end
      esc_seen = 1'b0;
      null_seen = 1'b0;
      len_cnt = '0;
      idx_cnt = '0;
      skip_row = 1'b0;
      return any;
    end
    if (skip_row) return 1'b0;
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == CH_NULL_MARK) begin
        if (null_seen) begin
          r = raise_err(ERR_DATA_AFTER_NULL);
          return 1'b1;
        end
        if (len_cnt != '0) begin
          r = raise_err(ERR_NULL_NONEMPTY);
          return 1'b1;
        end
        null_seen = 1'b1;
        return 1'b0;
      end
      case (b)
        CH_B: d = 8'd8;
        CH_F: d = 8'd12;
        CH_N: d = 8'd10;
        CH_R: d = 8'd13;
        CH_T: d = 8'd9;
        CH_V: d = 8'd11;
        default: d = b;
      endcase
      r = put_data(d);
      return 1'b1;
    end
    if (!g && b == CH_TAB) begin
      r = close_field(1'b0);
      return 1'b1;
    end
    if (!g && b == CH_BACKSLASH) begin
      esc_seen = 1'b1;
      return 1'b0;
    end
    r = put_data(b);
    return 1'b1;
  endfunction

  task automatic check_result(res_t e, res_t a);
    if (a.kind !== e.kind) begin
      $error("kind: expected %0h, actual %0h", e.kind, a.kind);
      fail_cnt++;
    end
    if (a.out_byte !== e.out_byte) begin
      $error("out_byte: expected %0h, actual %0h", e.out_byte, a.out_byte);
      fail_cnt++;
    end
    if (a.is_null !== e.is_null) begin
      $error("is_null: expected %0h, actual %0h", e.is_null, a.is_null);
      fail_cnt++;
    end
    if (a.field_len !== e.field_len) begin
      $error("field_len: expected %0d, actual %0d", e.field_len, a.field_len);
      fail_cnt++;
    end
    if (a.field_index !== e.field_index) begin
      $error("field_index: expected %0d, actual %0d", e.field_index, a.field_index);
      fail_cnt++;
    end
    if (a.row_end !== e.row_end) begin
      $error("row_end: expected %0h, actual %0h", e.row_end, a.row_end);
      fail_cnt++;
    end
    if (a.err_code !== e.err_code) begin
      $error("err_code: expected %0h, actual %0h", e.err_code, a.err_code);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : mon
    res_t pr;
    res_t act;
    bit got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        got = unescape_step(op, in_byte, in_glyph, pr);
        if (row_typed) begin
          if (row_any) row_out_q = {row_out_q, row_exp};
        end else if (got) begin
          row_out_q = {row_out_q, pr};
        end
        n_in++;
      end
      if (out_valid && !out_stall) begin
        act.kind = kind_t'(kind);
        act.out_byte = out_byte;
        act.is_null = is_null;
        act.field_len = field_len;
        act.field_index = field_index;
        act.row_end = row_end;
        act.err_code = err_t'(err_code);
        n_out++;
        if (act.kind == KIND_END) n_end++;
        if (act.kind == KIND_ERR) n_err++;
        if (row_out_q.size() == 0) begin
          $error("output transaction with nothing expected");
          fail_cnt++;
        end else begin
          check_result(row_out_q.pop_front(), act);
        end
      end
    end
  end

  task automatic send_item(input logic o, input logic [7:0] b, input logic g);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    in_byte <= b;
    in_glyph <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_rand++;
  endtask

  task automatic add_row(logic o, logic [7:0] b, logic g, bit typed, bit any, res_t r);
    stim_row_t s;
    s.op = o;
    s.b = b;
    s.g = g;
    s.typed = typed;
    s.any = any;
    s.r = r;
    directed_rows = {directed_rows, s};
  endtask

  task automatic send_row();
    int nf;
    int len;
    int pick;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 10))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      return;
    end
    calm = ($urandom_range(0, 4) == 0);
    nf = $urandom_range(1, 6);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_item(OP_BYTE, CH_TAB, 1'b0);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(OP_BYTE, CH_BACKSLASH, 1'b0);
        send_item(OP_BYTE, CH_NULL_MARK, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0)
          send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b0);
          end else if (pick < 65) begin
            send_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'b1);
          end else if (pick < 97) begin
            send_item(OP_BYTE, CH_BACKSLASH, 1'b0);
            send_item(OP_BYTE, (pick < 90) ? esc_set[$urandom_range(0, 7)]
                                           : 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
          end else begin
            send_item(OP_BYTE, CH_BACKSLASH, 1'b0);
            send_item(OP_BYTE, CH_NULL_MARK, 1'b0);
          end
        end
      end
    end
    if ($urandom_range(0, 19) == 0) send_item(OP_BYTE, CH_BACKSLASH, 1'b0);
    send_item(OP_EOR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // receiver: random stall before each result
  initial begin : rx
    int n;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    #50000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stim
    esc_seen = 1'b0;
    null_seen = 1'b0;
    len_cnt = '0;
    idx_cnt = '0;
    skip_row = 1'b0;

    add_row(OP_BYTE, 8'h61,        1'b0, 1, 1, data_res(8'h61));
    add_row(OP_BYTE, 8'hFF,        1'b1, 1, 1, data_res(8'hFF));
    add_row(OP_BYTE, CH_TAB,       1'b1, 0, 0, '0);
    add_row(OP_BYTE, CH_TAB,       1'b0, 1, 1, end_res(1'b0, 16'd3, 10'd0, 1'b0));
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 1, 0, '0);
    add_row(OP_BYTE, CH_NULL_MARK, 1'b0, 1, 0, '0);
    add_row(OP_BYTE, CH_TAB,       1'b0, 1, 1, end_res(1'b1, 16'd0, 10'd1, 1'b0));
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_V,         1'b1, 0, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b1, 0, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_NULL_MARK, 1'b0, 1, 1, err_res(ERR_NULL_NONEMPTY));
    add_row(OP_BYTE, 8'h00,        1'b0, 1, 0, '0);
    add_row(OP_EOR,  8'h00,        1'b0, 1, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_NULL_MARK, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, 8'h7A,        1'b0, 1, 1, err_res(ERR_DATA_AFTER_NULL));
    add_row(OP_EOR,  8'hFF,        1'b1, 1, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_NULL_MARK, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_BYTE, CH_NULL_MARK, 1'b0, 1, 1, err_res(ERR_DATA_AFTER_NULL));
    add_row(OP_EOR,  8'h00,        1'b0, 1, 0, '0);
    add_row(OP_BYTE, CH_BACKSLASH, 1'b0, 0, 0, '0);
    add_row(OP_EOR,  8'h00,        1'b0, 1, 1, err_res(ERR_EOR_BACKSLASH));
    add_row(OP_EOR,  8'h00,        1'b0, 1, 1, end_res(1'b0, 16'd0, 10'd0, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row_typed <= directed_rows[i].typed;
      row_any <= directed_rows[i].any;
      row_exp <= directed_rows[i].r;
      send_item(directed_rows[i].op, directed_rows[i].b, directed_rows[i].g);
    end
    row_typed <= 1'b0;

    n_rand = 0;
    while (n_rand < 870) send_row();
    in_valid <= 1'b0;

    while (row_out_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d input and %0d output transactions,", n_in, n_out);
    $display("  including %0d field ends and %0d error reports.", n_end, n_err);
    if (fail_cnt == 0 && row_out_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/ctru_pkg.sv
hdl/copy_text_row_unescaper.sv
hdl/ctru_checker.sv
verif/tb_copy_text_row_unescaper.sv
